@@ hdl/wpf_pkg.sv @@
package wpf_pkg;

  localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMIN = 32'sh8000_0000;
  localparam logic [30:0]        UMAX31 = 31'h7FFF_FFFF;

  // corner counter value before the first corner
  localparam logic [2:0] CORNER_NONE = 3'd7;
  localparam logic [1:0] LANE_LAST   = 2'd2;

  localparam logic signed [31:0] RST_X_LOW  = -32'sd78643;
  localparam logic signed [31:0] RST_X_HIGH = 32'sd78643;
  localparam logic signed [31:0] RST_Y_LOW  = -32'sd78643;
  localparam logic signed [31:0] RST_Y_HIGH = 32'sd78643;
  localparam logic signed [31:0] RST_Z_LOW  = 32'sd65536;
  localparam logic signed [31:0] RST_Z_HIGH = 32'sd65536;
  localparam logic [30:0]        RST_CRUISE = 31'd32768;
  localparam logic [30:0]        RST_ACCEL  = 31'd32768;

  typedef enum logic [2:0] {
    CFG_X_LOW  = 3'd0,
    CFG_X_HIGH = 3'd1,
    CFG_Y_LOW  = 3'd2,
    CFG_Y_HIGH = 3'd3,
    CFG_Z_LOW  = 3'd4,
    CFG_Z_HIGH = 3'd5,
    CFG_CRUISE = 3'd6,
    CFG_ACCEL  = 3'd7
  } cfg_idx_e;

  localparam logic CMD_START = 1'b0;

  typedef struct packed {
    logic               command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        delta_t;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [1:0]         segment_index;
  } out_beat_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SRC_POS,
    OP_CLOCK,
    OP_SRC_CORNER,
    OP_DIFF,
    OP_SQ_MUL,
    OP_SQ_ACC,
    OP_SQRT_SUM,
    OP_DIST,
    OP_DIV_SEG_GO,
    OP_SEG_LONG,
    OP_DIV_RAMP_GO,
    OP_RAMP_LONG,
    OP_MUL_DA,
    OP_SQRT_DA,
    OP_DIV_SHORT_GO,
    OP_SEG_SHORT,
    OP_DIV_DIR_GO,
    OP_DIR,
    OP_PLAN_END,
    OP_MUL_SS,
    OP_DIV_ACC_GO,
    OP_ACC,
    OP_MUL_DV,
    OP_SPEED,
    OP_MUL_DIRSPD,
    OP_MUL_DT,
    OP_STEP,
    OP_MUL_GAIN,
    OP_VEL,
    OP_PUSH
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] lane;
  } dp_cmd_t;

  typedef struct packed {
    logic replan;
    logic long_seg;
    logic div_done;
    logic sqrt_done;
  } dp_stat_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? QMIN : QMAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
    logic signed [31:0] r;
    if ((&v[65:31]) || !(|v[65:31])) begin
      r = v[31:0];
    end else begin
      r = v[65] ? QMIN : QMAX;
    end
    return r;
  endfunction

  function automatic logic [30:0] satu64(input logic [63:0] v);
    logic [30:0] r;
    if (|v[63:31]) begin
      r = UMAX31;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/wpf_div.sv @@
module wpf_div import wpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic [63:0] quot_o,
  output logic        done_o
);

  logic [63:0] num_q;
  logic [31:0] den_q;
  logic [31:0] rem_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q, num_q[63]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd63;
      end else if (busy_q) begin
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[62:0], ge};
      rem_q <= ge ? diff[31:0] : trial[31:0];
    end
  end

  assign quot_o = num_q;
  assign done_o = done_q;

endmodule

@@ hdl/wpf_sqrt.sv @@
module wpf_sqrt import wpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o,
  output logic        done_o
);

  logic [63:0] rad_q;
  logic [34:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [34:0] part;
  logic [34:0] trial;
  logic        ge;

  // one root bit per cycle
  assign part  = {rem_q[32:0], rad_q[63:62]};
  assign trial = {1'b0, root_q, 2'b01};
  assign ge    = part >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
      end else if (busy_q) begin
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= ge ? (part - trial) : part;
      root_q <= {root_q[30:0], ge};
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

@@ hdl/wpf_datapath.sv @@
module wpf_datapath import wpf_pkg::*; #(
  parameter int          FRAC_BITS = 16,
  parameter int unsigned GAIN      = 131072
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  in_beat_t   in_data_i,
  input  dp_cmd_t    cmd_i,
  output dp_stat_t   stat_o,
  output out_beat_t  out_data_o
);

  // configuration
  logic signed [31:0] x_low_q, x_high_q, y_low_q, y_high_q, z_low_q, z_high_q;
  logic [30:0]        cruise_q, accel_q;

  // segment state
  logic [2:0]         corner_q;
  logic [31:0]        clock_q;
  logic [30:0]        seg_q;
  logic [30:0]        ramp_q;
  logic signed [31:0] dir_q [3];
  logic signed [31:0] speed_q;
  logic signed [31:0] ref_q [3];

  // working registers
  logic signed [31:0] pos_q [3];
  logic [30:0]        dt_q;
  logic signed [31:0] src_q [3];
  logic [1:0]         tgt_q;
  logic signed [31:0] d_q [3];
  logic [63:0]        sum_q;
  logic [30:0]        dist_q;
  logic [30:0]        acc_q;
  logic signed [31:0] step_q [3];
  logic signed [31:0] vel_q [3];
  logic signed [65:0] prod_q;
  out_beat_t          out_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [65:0] prod_sh;
  logic signed [31:0] prod_qs;
  logic               div_start, sqrt_start;
  logic [63:0]        div_num, sqrt_rad;
  logic [31:0]        div_den;
  logic [63:0]        div_q;
  logic [31:0]        sqrt_root;
  logic               div_done, sqrt_done;
  logic [31:0]        two_a;
  logic [32:0]        long_num;
  logic [2:0]         cur;
  logic signed [31:0] tgt_c [3];
  logic signed [31:0] cur_c [3];
  logic [31:0]        mag [3];
  logic [1:0]         ln;
  logic [30:0]        seg_sat;
  logic [30:0]        dec_at;
  logic [31:0]        clock_sum_lo;
  logic [32:0]        clock_sum;

  function automatic logic signed [31:0] corner_coord(input logic [1:0] c, input logic [1:0] axis,
      input logic signed [31:0] xl, input logic signed [31:0] xh,
      input logic signed [31:0] yl, input logic signed [31:0] yh,
      input logic signed [31:0] zl, input logic signed [31:0] zh);
    logic signed [31:0] r;
    case (axis)
      2'd0:    r = (c == 2'd0 || c == 2'd3) ? xl : xh;
      2'd1:    r = (c < 2'd2) ? yl : yh;
      default: r = (c < 2'd2) ? zl : zh;
    endcase
    return r;
  endfunction

  assign ln    = cmd_i.lane;
  assign two_a = {accel_q, 1'b0};
  assign long_num = {1'b0, two_a} + {2'b00, dist_q};

  // next corner after the current one, wrapping past the last corner
  assign cur = (corner_q + 3'd1 >= 3'd4) ? 3'd0 : corner_q + 3'd1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tgt_c[i] = corner_coord(tgt_q, 2'(i), x_low_q, x_high_q, y_low_q, y_high_q,
                              z_low_q, z_high_q);
      cur_c[i] = corner_coord(cur[1:0], 2'(i), x_low_q, x_high_q, y_low_q, y_high_q,
                              z_low_q, z_high_q);
      mag[i]   = d_q[i][31] ? 32'(-d_q[i]) : 32'(d_q[i]);
    end
  end

  // fixed-point product, floor toward minus infinity
  assign prod_sh = prod_q >>> FRAC_BITS;
  assign prod_qs = sat66(prod_sh);
  assign mul_p   = mul_a * mul_b;
  assign seg_sat = satu64(div_q);
  assign dec_at  = seg_q - ramp_q;
  assign clock_sum = {1'b0, clock_q} + {2'b00, dt_q};
  assign clock_sum_lo = clock_sum[32] ? 32'hFFFF_FFFF : clock_sum[31:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_SQ_MUL: begin
        mul_a = {1'b0, mag[ln]};
        mul_b = {1'b0, mag[ln]};
      end
      OP_MUL_DA: begin
        mul_a = {2'b00, dist_q};
        mul_b = {2'b00, accel_q};
      end
      OP_MUL_SS: begin
        mul_a = {2'b00, cruise_q};
        mul_b = {2'b00, cruise_q};
      end
      OP_MUL_DV: begin
        mul_a = {2'b00, acc_q};
        mul_b = {2'b00, dt_q};
      end
      OP_MUL_DIRSPD: begin
        mul_a = {dir_q[ln][31], dir_q[ln]};
        mul_b = {speed_q[31], speed_q};
      end
      OP_MUL_DT: begin
        mul_a = {prod_qs[31], prod_qs};
        mul_b = {2'b00, dt_q};
      end
      OP_MUL_GAIN: begin
        mul_a = {1'b0, 32'(GAIN)};
        mul_b = {1'b0, 32'(0)} + 33'(sat33({ref_q[ln][31], ref_q[ln]} -
                                           {pos_q[ln][31], pos_q[ln]}));
        mul_b = {mul_b[31], mul_b[31:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    sqrt_start = 1'b0;
    sqrt_rad   = '0;
    case (cmd_i.op)
      OP_DIV_SEG_GO: begin
        div_start = 1'b1;
        div_num   = 64'(long_num) << FRAC_BITS;
        div_den   = {1'b0, cruise_q};
      end
      OP_DIV_RAMP_GO: begin
        div_start = 1'b1;
        div_num   = 64'(two_a) << FRAC_BITS;
        div_den   = {1'b0, cruise_q};
      end
      OP_DIV_SHORT_GO: begin
        div_start = 1'b1;
        div_num   = 64'({sqrt_root, 1'b0}) << FRAC_BITS;
        div_den   = {1'b0, cruise_q};
      end
      OP_DIV_DIR_GO: begin
        div_start = 1'b1;
        div_num   = 64'(mag[ln]) << FRAC_BITS;
        div_den   = {1'b0, dist_q};
      end
      OP_DIV_ACC_GO: begin
        div_start = 1'b1;
        div_num   = prod_q[63:0];
        div_den   = two_a;
      end
      OP_SQRT_SUM: begin
        sqrt_start = 1'b1;
        sqrt_rad   = sum_q;
      end
      OP_SQRT_DA: begin
        sqrt_start = 1'b1;
        sqrt_rad   = {prod_q[62:0], 1'b0};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  wpf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (div_q),
    .done_o  (div_done)
  );

  wpf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .root_o  (sqrt_root),
    .done_o  (sqrt_done)
  );

  // configuration and segment state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q  <= RST_X_LOW;
      x_high_q <= RST_X_HIGH;
      y_low_q  <= RST_Y_LOW;
      y_high_q <= RST_Y_HIGH;
      z_low_q  <= RST_Z_LOW;
      z_high_q <= RST_Z_HIGH;
      cruise_q <= RST_CRUISE;
      accel_q  <= RST_ACCEL;
      corner_q <= CORNER_NONE;
      clock_q  <= '0;
      seg_q    <= '0;
      ramp_q   <= '0;
      speed_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        dir_q[i] <= '0;
        ref_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_X_LOW:  x_low_q  <= cfg_wdata_i;
          CFG_X_HIGH: x_high_q <= cfg_wdata_i;
          CFG_Y_LOW:  y_low_q  <= cfg_wdata_i;
          CFG_Y_HIGH: y_high_q <= cfg_wdata_i;
          CFG_Z_LOW:  z_low_q  <= cfg_wdata_i;
          CFG_Z_HIGH: z_high_q <= cfg_wdata_i;
          CFG_CRUISE: cruise_q <= cfg_wdata_i[30:0];
          CFG_ACCEL:  accel_q  <= cfg_wdata_i[30:0];
          default:    accel_q  <= accel_q;
        endcase
      end
      case (cmd_i.op)
        OP_SRC_POS:    corner_q <= CORNER_NONE;
        OP_SRC_CORNER: corner_q <= cur;
        OP_CLOCK:      clock_q  <= clock_sum_lo;
        OP_SEG_LONG:   seg_q    <= seg_sat;
        OP_RAMP_LONG:  ramp_q   <= seg_sat;
        OP_SEG_SHORT: begin
          seg_q  <= seg_sat;
          ramp_q <= seg_sat >> 1;
        end
        OP_DIR: begin
          if (dist_q == '0) begin
            dir_q[ln] <= '0;
          end else if (d_q[ln][31]) begin
            dir_q[ln] <= -$signed(div_q[31:0]);
          end else begin
            dir_q[ln] <= $signed(div_q[31:0]);
          end
        end
        OP_PLAN_END: begin
          clock_q <= '0;
          speed_q <= '0;
          for (int i = 0; i < 3; i++) begin
            ref_q[i] <= src_q[i];
          end
        end
        OP_SPEED: begin
          // ramp up, hold, then ramp down
          if (clock_q <= {1'b0, ramp_q}) begin
            speed_q <= sat33({speed_q[31], speed_q} + {prod_qs[31], prod_qs});
          end else if (clock_q >= {1'b0, dec_at}) begin
            speed_q <= sat33({speed_q[31], speed_q} - {prod_qs[31], prod_qs});
          end
        end
        OP_STEP: ref_q[ln] <= sat33({ref_q[ln][31], ref_q[ln]} + {prod_qs[31], prod_qs});
        default: speed_q <= speed_q;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        pos_q[0] <= in_data_i.pos_x;
        pos_q[1] <= in_data_i.pos_y;
        pos_q[2] <= in_data_i.pos_z;
        dt_q     <= in_data_i.delta_t;
      end
      OP_SRC_POS: begin
        tgt_q <= 2'd0;
        for (int i = 0; i < 3; i++) begin
          src_q[i] <= pos_q[i];
        end
      end
      OP_SRC_CORNER: begin
        tgt_q <= cur[1:0] + 2'd1;
        for (int i = 0; i < 3; i++) begin
          src_q[i] <= cur_c[i];
        end
      end
      OP_DIFF: begin
        sum_q <= '0;
        for (int i = 0; i < 3; i++) begin
          d_q[i] <= sat33({tgt_c[i][31], tgt_c[i]} - {src_q[i][31], src_q[i]});
        end
      end
      OP_SQ_ACC: sum_q  <= sum_q + prod_q[63:0];
      OP_DIST:   dist_q <= sqrt_root[31] ? UMAX31 : sqrt_root[30:0];
      OP_ACC:    acc_q  <= seg_sat;
      OP_STEP:   step_q[ln] <= prod_qs;
      OP_VEL:    vel_q[ln]  <= sat33({step_q[ln][31], step_q[ln]} + {prod_qs[31], prod_qs});
      OP_PUSH: begin
        out_q.vel_x         <= vel_q[0];
        out_q.vel_y         <= vel_q[1];
        out_q.vel_z         <= vel_q[2];
        out_q.segment_index <= corner_q[1:0];
      end
      default: sum_q <= sum_q;
    endcase
    case (cmd_i.op)
      OP_SQ_MUL, OP_MUL_DA, OP_MUL_SS, OP_MUL_DV, OP_MUL_DIRSPD, OP_MUL_DT,
      OP_MUL_GAIN: prod_q <= mul_p;
      default:     prod_q <= prod_q;
    endcase
  end

  assign stat_o.replan    = clock_q > {1'b0, seg_q};
  assign stat_o.long_seg  = {1'b0, dist_q} >= two_a;
  assign stat_o.div_done  = div_done;
  assign stat_o.sqrt_done = sqrt_done;
  assign out_data_o       = out_q;

endmodule

@@ hdl/wpf_ctrl.sv @@
module wpf_ctrl import wpf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     in_command_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_CLOCK, S_CHECK, S_DIFF, S_SQ_MUL, S_SQ_ACC, S_DIST_GO,
    S_DIST_WAIT, S_BRANCH, S_SEG_WAIT, S_RAMP_GO, S_RAMP_WAIT, S_ROOT_GO,
    S_ROOT_WAIT, S_SHORT_WAIT, S_DIR_GO, S_DIR_WAIT, S_PLAN_END, S_SS, S_ACC_GO,
    S_ACC_WAIT, S_DV_MUL, S_SPEED, S_V_MUL, S_T_MUL, S_STEP, S_G_MUL, S_VEL,
    S_PUSH
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] lane_q, lane_d;
  logic       tick_q, tick_d;
  logic       out_valid_q, out_valid_d;
  dp_op_e     op;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    lane_d      = lane_q;
    tick_d      = tick_q;
    out_valid_d = out_valid_q && !out_ready_i;
    op          = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op      = OP_LOAD;
          tick_d  = in_command_i != CMD_START;
          state_d = (in_command_i == CMD_START) ? S_START : S_CLOCK;
        end
      end
      S_START: begin
        op      = OP_SRC_POS;
        state_d = S_DIFF;
      end
      S_CLOCK: begin
        op      = OP_CLOCK;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.replan) begin
          op      = OP_SRC_CORNER;
          state_d = S_DIFF;
        end else begin
          state_d = S_SS;
        end
      end
      S_DIFF: begin
        op      = OP_DIFF;
        lane_d  = 2'd0;
        state_d = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        op      = OP_SQ_MUL;
        state_d = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        op = OP_SQ_ACC;
        if (lane_q == LANE_LAST) begin
          state_d = S_DIST_GO;
        end else begin
          lane_d  = lane_q + 2'd1;
          state_d = S_SQ_MUL;
        end
      end
      S_DIST_GO: begin
        op      = OP_SQRT_SUM;
        state_d = S_DIST_WAIT;
      end
      S_DIST_WAIT: begin
        if (stat_i.sqrt_done) begin
          op      = OP_DIST;
          state_d = S_BRANCH;
        end
      end
      S_BRANCH: begin
        if (stat_i.long_seg) begin
          op      = OP_DIV_SEG_GO;
          state_d = S_SEG_WAIT;
        end else begin
          op      = OP_MUL_DA;
          state_d = S_ROOT_GO;
        end
      end
      S_SEG_WAIT: begin
        if (stat_i.div_done) begin
          op      = OP_SEG_LONG;
          state_d = S_RAMP_GO;
        end
      end
      S_RAMP_GO: begin
        op      = OP_DIV_RAMP_GO;
        state_d = S_RAMP_WAIT;
      end
      S_RAMP_WAIT: begin
        if (stat_i.div_done) begin
          op      = OP_RAMP_LONG;
          lane_d  = 2'd0;
          state_d = S_DIR_GO;
        end
      end
      S_ROOT_GO: begin
        op      = OP_SQRT_DA;
        state_d = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        if (stat_i.sqrt_done) begin
          op      = OP_DIV_SHORT_GO;
          state_d = S_SHORT_WAIT;
        end
      end
      S_SHORT_WAIT: begin
        if (stat_i.div_done) begin
          op      = OP_SEG_SHORT;
          lane_d  = 2'd0;
          state_d = S_DIR_GO;
        end
      end
      S_DIR_GO: begin
        op      = OP_DIV_DIR_GO;
        state_d = S_DIR_WAIT;
      end
      S_DIR_WAIT: begin
        if (stat_i.div_done) begin
          op = OP_DIR;
          if (lane_q == LANE_LAST) begin
            state_d = S_PLAN_END;
          end else begin
            lane_d  = lane_q + 2'd1;
            state_d = S_DIR_GO;
          end
        end
      end
      S_PLAN_END: begin
        op      = OP_PLAN_END;
        state_d = tick_q ? S_SS : S_IDLE;
      end
      S_SS: begin
        op      = OP_MUL_SS;
        state_d = S_ACC_GO;
      end
      S_ACC_GO: begin
        op      = OP_DIV_ACC_GO;
        state_d = S_ACC_WAIT;
      end
      S_ACC_WAIT: begin
        if (stat_i.div_done) begin
          op      = OP_ACC;
          state_d = S_DV_MUL;
        end
      end
      S_DV_MUL: begin
        op      = OP_MUL_DV;
        state_d = S_SPEED;
      end
      S_SPEED: begin
        op      = OP_SPEED;
        lane_d  = 2'd0;
        state_d = S_V_MUL;
      end
      S_V_MUL: begin
        op      = OP_MUL_DIRSPD;
        state_d = S_T_MUL;
      end
      S_T_MUL: begin
        op      = OP_MUL_DT;
        state_d = S_STEP;
      end
      S_STEP: begin
        op      = OP_STEP;
        state_d = S_G_MUL;
      end
      S_G_MUL: begin
        op      = OP_MUL_GAIN;
        state_d = S_VEL;
      end
      S_VEL: begin
        op = OP_VEL;
        if (lane_q == LANE_LAST) begin
          state_d = S_PUSH;
        end else begin
          lane_d  = lane_q + 2'd1;
          state_d = S_V_MUL;
        end
      end
      S_PUSH: begin
        if (slot_free) begin
          op          = OP_PUSH;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lane_q      <= '0;
      tick_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lane_q      <= lane_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign cmd_o.op    = op;
  assign cmd_o.lane  = lane_q;

endmodule

@@ hdl/waypoint_path_follower.sv @@
// channel | signals                              | beat
// --------+--------------------------------------+-------------------------------
// in      | in_valid_i / in_ready_o / in_data_i  | command, position, delta_t
// out     | out_valid_o / out_ready_i / out_data_o | velocity setpoint, segment
// cfg     | cfg_we_i / cfg_addr_i / cfg_wdata_i  | one register per write
//
// a tick spends most of its time in the radix-2 divider for the ramp
// acceleration; a tick that moves to the next corner adds one square root, then
// either two divisions or a second square root and one division, then three
// more divisions for the unit direction; a start beat gives no result.
// reset clears the controller and the path state at once, no clearing pass.
// a finished result waits in the output register while the next beat is taken;
// only the final copy into that register waits on out_ready_i.
module waypoint_path_follower import wpf_pkg::*; #(
  parameter int          FRAC_BITS = 16,
  parameter int unsigned GAIN      = 131072
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input beats
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_beat_t   in_data_i,
  // result beats
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_beat_t  out_data_o,
  // register writes
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);

  // sequencing commands down, unit and compare status up
  dp_cmd_t  cmd;
  dp_stat_t stat;

  wpf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_command_i (in_data_i.command),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd),
    .stat_i       (stat)
  );

  // holds the rectangle, the segment plan, the shared multiplier,
  // the divider and the square root unit
  wpf_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .GAIN      (GAIN)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule
